// ----- sv/cpp_pkg.sv -----
// Shared constants and types for the circle point projection pipeline.
// Used by circle_point_projection; depends on nothing else.
package cpp_pkg;

  // Default coordinate format, signed fixed point.
  localparam int CPP_COORD_WIDTH = 32;
  localparam int CPP_FRAC_BITS   = 16;

  // Fixed register widths.
  localparam int AXIS_W   = 18;
  localparam int RADIUS_W = 31;

  // Direction normalization and length arithmetic.
  localparam int NORM_W     = 30;  // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int LEN2_W     = 62;  // sum of three squares
  localparam int ROOT_STEPS = 32;  // one square root digit per stage
  localparam int ROOT_W     = 31;  // floor(sqrt(len2)) fits in 31 bits
  localparam int NUM_W      = 62;  // radius * magnitude + rounding term
  localparam int QUOT_W     = 33;  // one quotient bit per stage

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 3'd6;

  // Sideband carried through the square root stages.
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   fb;
    logic                   last;
  } rt_side_t;

  // Sideband carried through the divider stages.
  typedef struct packed {
    logic [2:0] neg;
    logic       fb;
    logic       last;
  } dv_side_t;

endpackage

// ----- sv/circle_point_projection.sv -----
// Throughput: one transaction per cycle; busy stays low, so start may be high every cycle.
// The datapath holds a 32-stage square root pipeline and a 33-stage divider pipeline.
// The receiver cannot stall: each result is shown for one cycle with out_valid_o high.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the register defaults:
// center at the origin, axis along +z, radius 1.0.
module circle_point_projection #(
  parameter int COORD_WIDTH = cpp_pkg::CPP_COORD_WIDTH,
  parameter int FRAC_BITS   = cpp_pkg::CPP_FRAC_BITS
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  // Configuration write port.
  input  logic                                            cfg_we_i,
  input  logic [cpp_pkg::REG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] cfg_wdata_i,
  // Command side.
  input  logic                                            start,
  output logic                                            busy,
  input  logic signed [COORD_WIDTH-1:0]                   point_x_i,
  input  logic signed [COORD_WIDTH-1:0]                   point_y_i,
  input  logic signed [COORD_WIDTH-1:0]                   point_z_i,
  input  logic                                            last_in_i,
  // Result side.
  output logic                                            out_valid_o,
  output logic signed [COORD_WIDTH-1:0]                   proj_x_o,
  output logic signed [COORD_WIDTH-1:0]                   proj_y_o,
  output logic signed [COORD_WIDTH-1:0]                   proj_z_o,
  output logic                                            used_fallback_o,
  output logic                                            saturated_o,
  output logic                                            last_out_o
);
  import cpp_pkg::*;

  // Datapath widths, all following from the coordinate format.
  localparam int DW   = COORD_WIDTH + 1;                 // point minus center
  localparam int AXW  = FRAC_BITS + 2;                   // clamped axis, +-1.0
  localparam int P1W  = DW + AXW;                        // d * axis
  localparam int DOTW = COORD_WIDTH + 4;                 // dot product
  localparam int P2W  = DOTW + AXW;                      // dot * axis
  localparam int VW   = COORD_WIDTH + 5;                 // in-plane vector
  localparam int MW   = VW;                              // its magnitudes
  localparam int NW   = (MW > NORM_W) ? MW : NORM_W;     // normalizer width
  localparam int LZW  = $clog2(NW);
  localparam int OW   = ((COORD_WIDTH > QUOT_W + 1) ? COORD_WIDTH : QUOT_W + 1) + 1;
  localparam int CLW  = ((AXIS_W > AXW) ? AXIS_W : AXW) + 1;
  localparam int LATENCY = 11 + ROOT_STEPS + QUOT_W + 1;

  localparam logic [AXIS_W-1:0]   AXIS_ONE   = AXIS_W'(64'd1 << FRAC_BITS);
  localparam logic [RADIUS_W-1:0] RADIUS_ONE = RADIUS_W'(64'd1 << FRAC_BITS);
  localparam logic signed [CLW-1:0] CL_ONE   = CLW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [AXW-1:0] THR      = AXW'((9 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [P1W:0]   HALF1    = (P1W + 1)'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [P2W:0]   HALF2    = (P2W + 1)'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [OW-1:0]  SAT_HI   = OW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [OW-1:0]  SAT_LO   = -SAT_HI - OW'(1);

  // ------------------------------------------------------------------------
  // Configuration registers. The user must let writes arrive only while the
  // pipeline is empty; the block does not enforce it. Every stage reads them directly.
  // ------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] center_q [3];
  logic signed [AXIS_W-1:0]      axis_q   [3];
  logic [RADIUS_W-1:0]           radius_q;
  logic signed [AXW-1:0]         ax_q     [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      axis_q[0]   <= '0;
      axis_q[1]   <= '0;
      axis_q[2]   <= AXIS_ONE;
      radius_q    <= RADIUS_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X: center_q[0] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CENTER_Y: center_q[1] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CENTER_Z: center_q[2] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_AXIS_X:   axis_q[0]   <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Y:   axis_q[1]   <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Z:   axis_q[2]   <= cfg_wdata_i[AXIS_W-1:0];
        REG_RADIUS:   radius_q    <= cfg_wdata_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // The axis is clamped to +-1.0 once, into a shadow register that follows
  // the written value in the next cycle.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (CLW'(axis_q[i]) > CL_ONE) begin
        ax_q[i] <= AXW'(CL_ONE);
      end else if (CLW'(axis_q[i]) < -CL_ONE) begin
        ax_q[i] <= AXW'(-CL_ONE);
      end else begin
        ax_q[i] <= AXW'(axis_q[i]);
      end
    end
  end

  // The pipeline never holds, so a new transaction can be taken in every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic signed [COORD_WIDTH-1:0] pt [3];
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // Valid and last bits of the front stages, one bit per stage.
  logic [8:0] pv_q;
  logic [8:0] pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[7:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= {pl_q[7:0], last_in_i};
  end

  // ------------------------------------------------------------------------
  // Front stages: relative point, axis removal, fallback, normalization.
  // ------------------------------------------------------------------------
  logic signed [DW-1:0]   d_q  [3];
  logic signed [DW-1:0]   d2_q [3];
  logic signed [DW-1:0]   d3_q [3];
  logic signed [DW-1:0]   d4_q [3];
  logic signed [P1W-1:0]  p1_q [3];
  logic signed [DOTW-1:0] dot_q;
  logic signed [P2W-1:0]  p2_q [3];
  logic signed [VW-1:0]   v_q  [3];
  logic [MW-1:0]          mag_q  [3];
  logic [MW-1:0]          mag7_q [3];
  logic [2:0]             neg6_q, neg7_q, neg8_q, neg9_q;
  logic                   fb6_q, fb7_q, fb8_q, fb9_q;
  logic [LZW-1:0]         lz_q;
  logic [NORM_W-1:0]      mn_q  [3];
  logic [NORM_W-1:0]      mn9_q [3];
  logic [2*NORM_W-1:0]    sq_q  [3];

  // Stage 3 and stage 5 rounding, stage 6 fallback and magnitudes,
  // stage 7 leading-zero count, stage 8 shift.
  logic signed [DOTW-1:0] dot_d;
  logic signed [VW-1:0]   v_d   [3];
  logic signed [VW-1:0]   sel   [3];
  logic signed [VW-1:0]   fv    [3];
  logic signed [VW-1:0]   axe   [3];
  logic [MW-1:0]          mag_d [3];
  logic [2:0]             neg_d;
  logic                   vzero;
  logic                   big_x;
  logic signed [AXW-1:0]  abs_x;
  logic [NW-1:0]          orv;
  logic [LZW-1:0]         lz_d;
  logic [NORM_W-1:0]      mn_d  [3];

  always_comb begin
    logic signed [P1W:0] t1;
    logic signed [P2W:0] t2;
    logic [NW-1:0]       sh;
    dot_d = '0;
    for (int i = 0; i < 3; i++) begin
      t1    = (P1W + 1)'(p1_q[i]) + HALF1;
      dot_d = dot_d + DOTW'(t1 >>> FRAC_BITS);
    end
    for (int i = 0; i < 3; i++) begin
      t2     = (P2W + 1)'(p2_q[i]) + HALF2;
      v_d[i] = VW'(d4_q[i]) - VW'(t2 >>> FRAC_BITS);
    end

    // A zero in-plane part falls back to the axis crossed with x or y.
    vzero = (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
    abs_x = (ax_q[0] < 0) ? -ax_q[0] : ax_q[0];
    big_x = abs_x > THR;
    for (int i = 0; i < 3; i++) begin
      axe[i] = VW'(ax_q[i]);
    end
    fv[0] = big_x ? -axe[2] : '0;
    fv[1] = big_x ? '0 : axe[2];
    fv[2] = big_x ? axe[0] : -axe[1];
    if ((fv[0] == '0) && (fv[1] == '0) && (fv[2] == '0)) begin
      fv[1] = VW'(1);
    end
    for (int i = 0; i < 3; i++) begin
      sel[i]   = vzero ? fv[i] : v_q[i];
      neg_d[i] = sel[i][VW-1];
      mag_d[i] = neg_d[i] ? MW'(-sel[i]) : MW'(sel[i]);
    end

    // The OR of the magnitudes has its leading one where the largest has.
    orv  = NW'(mag_q[0] | mag_q[1] | mag_q[2]);
    lz_d = '0;
    for (int k = 0; k < NW; k++) begin
      if (orv[k]) begin
        lz_d = LZW'(NW - 1 - k);
      end
    end

    // Leading one to the top, then the top bits; dropped bits truncate.
    for (int i = 0; i < 3; i++) begin
      sh      = NW'(mag7_q[i]) << lz_q;
      mn_d[i] = sh[NW-1 -: NORM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]    <= DW'(pt[i]) - DW'(center_q[i]);
      p1_q[i]   <= P1W'(d_q[i]) * P1W'(ax_q[i]);
      d2_q[i]   <= d_q[i];
      d3_q[i]   <= d2_q[i];
      p2_q[i]   <= P2W'(dot_q) * P2W'(ax_q[i]);
      d4_q[i]   <= d3_q[i];
      v_q[i]    <= v_d[i];
      mag_q[i]  <= mag_d[i];
      mag7_q[i] <= mag_q[i];
      mn_q[i]   <= mn_d[i];
      mn9_q[i]  <= mn_q[i];
      sq_q[i]   <= mn_q[i] * mn_q[i];
    end
    dot_q  <= dot_d;
    neg6_q <= neg_d;
    fb6_q  <= vzero;
    neg7_q <= neg6_q;
    fb7_q  <= fb6_q;
    lz_q   <= lz_d;
    neg8_q <= neg7_q;
    fb8_q  <= fb7_q;
    neg9_q <= neg8_q;
    fb9_q  <= fb8_q;
  end

  // ------------------------------------------------------------------------
  // Square root of the squared length, one result digit per stage.
  // ------------------------------------------------------------------------
  logic [LEN2_W-1:0] rt_rem_q  [ROOT_STEPS+1];
  logic [63:0]       rt_res_q  [ROOT_STEPS+1];
  rt_side_t          rt_side_q [ROOT_STEPS+1];
  logic              rt_vld_q  [ROOT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q[0] <= 1'b0;
    end else begin
      rt_vld_q[0] <= pv_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    rt_rem_q[0] <= LEN2_W'(sq_q[0]) + LEN2_W'(sq_q[1]) + LEN2_W'(sq_q[2]);
    rt_res_q[0] <= '0;
    for (int i = 0; i < 3; i++) begin
      rt_side_q[0].mag[i] <= mn9_q[i];
    end
    rt_side_q[0].neg  <= neg9_q;
    rt_side_q[0].fb   <= fb9_q;
    rt_side_q[0].last <= pl_q[8];
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] RBIT = 64'd1 << (LEN2_W - 2 * k);
    logic [63:0] trial;
    logic        ge;

    assign trial = rt_res_q[k] + RBIT;
    assign ge    = {2'b00, rt_rem_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_rem_q[k+1]  <= ge ? LEN2_W'({2'b00, rt_rem_q[k]} - trial) : rt_rem_q[k];
      rt_res_q[k+1]  <= ge ? ((rt_res_q[k] >> 1) + RBIT) : (rt_res_q[k] >> 1);
      rt_side_q[k+1] <= rt_side_q[k];
    end
  end

  // ------------------------------------------------------------------------
  // Offset = round(radius * m / L), restoring division, one bit per stage.
  // ------------------------------------------------------------------------
  logic [ROOT_W-1:0]   len;
  logic [NUM_W-2:0]    rm [3];
  logic [NUM_W-1:0]    dv_rem_q  [QUOT_W+1][3];
  logic [QUOT_W-1:0]   dv_quo_q  [QUOT_W+1][3];
  logic [ROOT_W-1:0]   dv_len_q  [QUOT_W+1];
  dv_side_t            dv_side_q [QUOT_W+1];
  logic                dv_vld_q  [QUOT_W+1];

  assign len = rt_res_q[ROOT_STEPS][ROOT_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rm[i] = radius_q * rt_side_q[ROOT_STEPS].mag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= rt_vld_q[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] <= NUM_W'(rm[i]) + NUM_W'(len[ROOT_W-1:1]);
      dv_quo_q[0][i] <= '0;
    end
    dv_len_q[0]       <= len;
    dv_side_q[0].neg  <= rt_side_q[ROOT_STEPS].neg;
    dv_side_q[0].fb   <= rt_side_q[ROOT_STEPS].fb;
    dv_side_q[0].last <= rt_side_q[ROOT_STEPS].last;
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int SH = QUOT_W - 1 - j;
    logic [63:0] dvs;
    logic [2:0]  ge;

    assign dvs = 64'(dv_len_q[j]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = 64'(dv_rem_q[j][i]) >= dvs;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[j+1][i] <= ge[i] ? NUM_W'(64'(dv_rem_q[j][i]) - dvs) : dv_rem_q[j][i];
        dv_quo_q[j+1][i] <= {dv_quo_q[j][i][QUOT_W-2:0], ge[i]};
      end
      dv_len_q[j+1]  <= dv_len_q[j];
      dv_side_q[j+1] <= dv_side_q[j];
    end
  end

  // ------------------------------------------------------------------------
  // Output stage: center plus signed offset, saturated to the coordinate range.
  // ------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] proj_d [3];
  logic [2:0]                    sat_d;
  logic signed [COORD_WIDTH-1:0] proj_q [3];
  logic                          out_vld_q;
  logic                          fb_q;
  logic                          sat_q;
  logic                          last_q;

  always_comb begin
    logic signed [OW-1:0] qs;
    logic signed [OW-1:0] o;
    for (int i = 0; i < 3; i++) begin
      qs = OW'(dv_quo_q[QUOT_W][i]);
      o  = OW'(center_q[i]) + (dv_side_q[QUOT_W].neg[i] ? -qs : qs);
      if (o > SAT_HI) begin
        proj_d[i] = COORD_WIDTH'(SAT_HI);
        sat_d[i]  = 1'b1;
      end else if (o < SAT_LO) begin
        proj_d[i] = COORD_WIDTH'(SAT_LO);
        sat_d[i]  = 1'b1;
      end else begin
        proj_d[i] = COORD_WIDTH'(o);
        sat_d[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld_q[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      proj_q[i] <= proj_d[i];
    end
    fb_q   <= dv_side_q[QUOT_W].fb;
    sat_q  <= |sat_d;
    last_q <= dv_side_q[QUOT_W].last;
  end

  assign out_valid_o     = out_vld_q;
  assign proj_x_o        = proj_q[0];
  assign proj_y_o        = proj_q[1];
  assign proj_z_o        = proj_q[2];
  assign used_fallback_o = fb_q;
  assign saturated_o     = sat_q;
  assign last_out_o      = last_q;

`ifndef SYNTHESIS
  // Every result strobe goes back to an earlier accepted transaction.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  // Normalization leaves the largest magnitude with its top bit set.
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[7] |-> ((mn_q[0] | mn_q[1] | mn_q[2]) >> (NORM_W - 1)) == NORM_W'(1))
    else $error("direction magnitudes not normalized");

  // The length of a normalized direction lies in [2^29, 2^31).
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_vld_q[ROOT_STEPS] |-> (rt_res_q[ROOT_STEPS] >= (64'd1 << (NORM_W - 1))) &&
                             (rt_res_q[ROOT_STEPS] <  (64'd1 << ROOT_W)))
    else $error("square root out of range");

  // After the last divider stage every remainder is below the divisor.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[QUOT_W] |-> (dv_rem_q[QUOT_W][0] < NUM_W'(dv_len_q[QUOT_W])) &&
                         (dv_rem_q[QUOT_W][1] < NUM_W'(dv_len_q[QUOT_W])) &&
                         (dv_rem_q[QUOT_W][2] < NUM_W'(dv_len_q[QUOT_W])))
    else $error("divider remainder not reduced");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for circle_point_projection: directed points first, then random phases.
// Uses cpp_pkg for the register indexes and widths; needs only the RTL to build.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpp_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int ONE = 1 << FB;
  // The fallback switch point, 0.9 in Q16.16; the comparison against it is strict.
  localparam int X_LIMIT = (9 * ONE + 5) / 10;
  localparam int DRAIN_CYCLES = 90;  // longer than the pipeline depth

  typedef logic [31:0] reg_set_t [7];

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic fb, sat, last;
  } projection_t;

  // Holds a copy of the register file, predicts each projection and checks results in order.
  class projection_board;
    logic signed [CW-1:0] center [3];
    logic [AXIS_W-1:0] axis [3];
    logic [RADIUS_W-1:0] radius;
    projection_t pending_q [$];
    int errors, checked, fallbacks, clamps;

    function void defaults();
      center = '{0, 0, 0};
      axis = '{0, 0, AXIS_W'(ONE)};
      radius = RADIUS_W'(ONE);
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_CENTER_X: center[0] = v;
        REG_CENTER_Y: center[1] = v;
        REG_CENTER_Z: center[2] = v;
        REG_AXIS_X: axis[0] = v[AXIS_W-1:0];
        REG_AXIS_Y: axis[1] = v[AXIS_W-1:0];
        REG_AXIS_Z: axis[2] = v[AXIS_W-1:0];
        REG_RADIUS: radius = v[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    // Fixed-point product with round-half-up, floor semantics on negative values.
    function longint fx_mul(longint x, longint y);
      longint hi, lo;
      hi = x >>> FB;
      lo = x - (hi <<< FB);
      return hi * y + ((lo * y + (ONE >>> 1)) >>> FB);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_point(logic signed [CW-1:0] px, py, pz, logic last);
      longint c [3], a [3], d [3], v [3], dot, o;
      longint unsigned mag [3], top, len, q;
      logic signed [CW-1:0] res [3];
      projection_t e;
      c[0] = center[0]; c[1] = center[1]; c[2] = center[2];
      d[0] = px - c[0]; d[1] = py - c[1]; d[2] = pz - c[2];
      for (int i = 0; i < 3; i++) begin
        a[i] = $signed(axis[i]);
        if (a[i] > ONE) a[i] = ONE;
        if (a[i] < -ONE) a[i] = -ONE;
      end
      dot = fx_mul(d[0], a[0]) + fx_mul(d[1], a[1]) + fx_mul(d[2], a[2]);
      for (int i = 0; i < 3; i++) v[i] = d[i] - fx_mul(dot, a[i]);
      e.fb = (v[0] == 0 && v[1] == 0 && v[2] == 0);
      if (e.fb) begin
        // Direction perpendicular to the axis: cross with x, or with y when the axis is near x.
        if ((a[0] < 0 ? -a[0] : a[0]) > X_LIMIT) begin
          v[0] = -a[2]; v[1] = 0; v[2] = a[0];
        end else begin
          v[0] = 0; v[1] = a[2]; v[2] = -a[1];
        end
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) v[1] = 1;
      end
      top = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > top) top = mag[i];
      end
      while (top >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
        top >>= 1;
      end
      while (top < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
        top <<= 1;
      end
      len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      e.sat = 0;
      for (int i = 0; i < 3; i++) begin
        q = (longint'(radius) * mag[i] + (len >> 1)) / len;
        o = c[i] + (v[i] < 0 ? -longint'(q) : longint'(q));
        if (o > 64'sh7fffffff) begin
          o = 64'sh7fffffff; e.sat = 1;
        end
        if (o < -64'sh80000000) begin
          o = -64'sh80000000; e.sat = 1;
        end
        res[i] = o[CW-1:0];
      end
      e.x = res[0]; e.y = res[1]; e.z = res[2];
      e.last = last;
      pending_q.push_back(e);
    endfunction

    function void check(projection_t got);
      projection_t e;
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      fallbacks += e.fb;
      clamps += e.sat;
      if (got.x !== e.x) begin
        $error("proj_x: expected %0d, got %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("proj_y: expected %0d, got %0d", e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $error("proj_z: expected %0d, got %0d", e.z, got.z); errors++;
      end
      if (got.fb !== e.fb) begin
        $error("used_fallback: expected %0b, got %0b", e.fb, got.fb); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated: expected %0b, got %0b", e.sat, got.sat); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_out: expected %0b, got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic start, busy;
  logic signed [CW-1:0] point_x_i, point_y_i, point_z_i;
  logic last_in_i;
  logic out_valid_o, used_fallback_o, saturated_o, last_out_o;
  logic signed [CW-1:0] proj_x_o, proj_y_o, proj_z_o;

  projection_board board;
  int sent;

  circle_point_projection u_top (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Outputs are sampled mid-cycle, where they hold the value seen by the accepting edge.
  always @(negedge clk_i) begin
    projection_t got;
    if (rst_ni && out_valid_o) begin
      got.x = proj_x_o; got.y = proj_y_o; got.z = proj_z_o;
      got.fb = used_fallback_o; got.sat = saturated_o; got.last = last_out_o;
      board.check(got);
    end
  end

  // Offers one point and holds it until a transaction takes place. The sender may idle first.
  task automatic send_point(logic [31:0] x, y, z, logic last, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    point_x_i <= x; point_y_i <= y; point_z_i <= z; last_in_i <= last;
    do @(negedge clk_i); while (busy);
    board.note_point(x, y, z, last);
    sent++;
    @(posedge clk_i);
  endtask

  // Stops the stimulus and waits until the pipeline is empty, so registers may change.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all seven registers on back-to-back cycles.
  task automatic load_regs(reg_set_t vals);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= REG_IDX_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      board.set_reg(REG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return $urandom_range(1 << 22) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_axis_part();
    case ($urandom_range(5))
      0: return 0;
      1: return ONE;
      2: return -ONE;
      3: return $urandom_range(2 * ONE) - ONE;
      4: return X_LIMIT + $urandom_range(1);
      default: return {{14{1'b0}}, 18'($urandom)};  // may exceed unit range and get clamped
    endcase
  endfunction

  function automatic reg_set_t pick_regs();
    reg_set_t r;
    int k;
    r[REG_CENTER_X] = pick_coord();
    r[REG_CENTER_Y] = pick_coord();
    r[REG_CENTER_Z] = pick_coord();
    r[REG_AXIS_X] = 0; r[REG_AXIS_Y] = 0; r[REG_AXIS_Z] = 0;
    case ($urandom_range(3))
      0: begin
        // A unit axis along one coordinate, with either sign.
        k = $urandom_range(2);
        r[REG_AXIS_X + k] = $urandom_range(1) ? ONE : -ONE;
      end
      1: begin
        // Nearly along x, at or just past the switch point, so either fallback cross product can be chosen.
        r[REG_AXIS_X] = ($urandom_range(1) ? 1 : -1) * (X_LIMIT + $urandom_range(1));
        r[REG_AXIS_Y] = $urandom_range(4000) - 2000;
        r[REG_AXIS_Z] = $urandom_range(4000) - 2000;
      end
      default: begin
        r[REG_AXIS_X] = pick_axis_part();
        r[REG_AXIS_Y] = pick_axis_part();
        r[REG_AXIS_Z] = pick_axis_part();
      end
    endcase
    case ($urandom_range(4))
      0: r[REG_RADIUS] = 1;
      1: r[REG_RADIUS] = 32'h7fffffff;
      2: r[REG_RADIUS] = ONE;
      3: r[REG_RADIUS] = $urandom_range(1 << 24, 1);
      default: r[REG_RADIUS] = {1'b0, 31'($urandom)};
    endcase
    return r;
  endfunction

  // Random point: mostly near the center or along the axis, where the rounding and
  // the degenerate case live, plus fully random coordinates.
  task automatic random_point(int idle_pct);
    logic [31:0] p [3];
    longint t;
    int sel;
    sel = $urandom_range(99);
    t = $urandom_range(64) - 32;
    for (int i = 0; i < 3; i++) begin
      if (sel < 35) p[i] = $urandom;
      else if (sel < 65) p[i] = board.center[i] + $urandom_range(1 << 21) - (1 << 20);
      else if (sel < 90) p[i] = 32'(board.center[i] + t * longint'($signed(board.axis[i])));
      else p[i] = board.center[i];
    end
    send_point(p[0], p[1], p[2], $urandom_range(1), idle_pct);
  endtask

  task automatic directed();
    reg_set_t r;
    // Reset settings: center at the origin, axis along +z, radius 1.0.
    send_point(0, 0, 0, 1, 0);                            // point at the center
    send_point(0, 0, 32'h00050000, 0, 0);                 // on the axis
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 1, 0);
    send_point(32'h00010000, 32'hffff0000, 32'h12345678, 0, 0);
    drain();
    // Far corner center with the largest radius, so the offsets can drive a coordinate into saturation.
    r = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, ONE, 0, 0, 32'h7fffffff};
    load_regs(r);
    send_point(0, 0, 0, 0, 0);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
    drain();
    // Axis along -x, beyond the fallback switch point; zero radius returns the center.
    r = '{32'h00010000, 32'hfffe0000, 0, -ONE, 0, 0, 0};
    load_regs(r);
    send_point(32'h00010000, 32'hfffe0000, 0, 1, 0);
    send_point(32'h00090000, 32'hfffe0000, 0, 0, 0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1, 0);
    drain();
    // Zero axis: nothing removed, fallback falls through to +y. Radius of one LSB.
    r = '{0, 0, 0, 0, 0, 0, 1};
    load_regs(r);
    send_point(0, 0, 0, 0, 0);
    send_point(32'h00000001, 32'hffffffff, 32'h00000003, 1, 0);
    drain();
    // Axis components outside unit range, clamped before use.
    r = '{32'h00100000, 0, 32'hfff00000, 32'h1ffff, 32'h20000, 32'h10001, ONE};
    load_regs(r);
    send_point(32'h00100000, 0, 32'hfff00000, 0, 0);
    send_point(32'h00200000, 32'h00300000, 32'h00400000, 1, 0);
    send_point($urandom, $urandom, $urandom, 0, 0);
    drain();
    // Axis at exactly the switch point, not above it.
    r = '{0, 0, 0, X_LIMIT, 0, 0, ONE};
    load_regs(r);
    send_point(0, 0, 0, 1, 0);
    r[REG_AXIS_X] = X_LIMIT + 1;
    drain();
    load_regs(r);
    send_point(0, 0, 0, 0, 0);
    drain();
  endtask

  initial begin
    board = new();
    board.defaults();
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    start = 1'b0; point_x_i = '0; point_y_i = '0; point_z_i = '0; last_in_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    // Nine random phases: the sender idles often, then more often, then never.
    for (int ph = 0; ph < 9; ph++) begin
      int idle_pct;
      idle_pct = (ph < 3) ? 31 : (ph < 6) ? 53 : 0;
      load_regs(pick_regs());
      for (int n = 0; n < 155; n++) begin
        random_point(idle_pct);
        // Now and then a longer burst with no gaps at all.
        if ($urandom_range(49) == 0)
          repeat ($urandom_range(20, 5)) random_point(0);
      end
      drain();
    end
    $display("tb: %0d points sent, %0d projections checked", sent, board.checked);
    $display("tb: %0d took the fallback direction, %0d were clamped",
             board.fallbacks, board.clamps);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
